[sv/dhmvs_pkg.sv]
// Shared types, constants and index tables for the delayed hit/miss vector store.
package dhmvs_pkg;

    localparam int FEATURE_COUNT = 64;
    localparam int LANES = 4;
    localparam int CHUNKS = FEATURE_COUNT / LANES;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int LANE_W = 32;
    localparam int IDX_W = 4;
    localparam int IDX_COUNT = 1 << IDX_W;
    localparam int PORT_LANES = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [CHUNK_W-1:0] chunk_t;
    typedef logic [LANES-1:0][LANE_W-1:0] row_t;
    typedef logic [IDX_COUNT-1:0][CHUNK_W-1:0] chunk_tab_t;

    typedef struct packed {
        logic [IDX_W-1:0] chunk_index;
        logic is_hit;
        logic do_update;
        logic end_of_set;
        logic signed [LANE_W-1:0] lane_a;
        logic signed [LANE_W-1:0] lane_b;
        logic signed [LANE_W-1:0] lane_c;
        logic signed [LANE_W-1:0] lane_d;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_chunk_index;
        logic signed [LANE_W-1:0] hit_a;
        logic signed [LANE_W-1:0] hit_b;
        logic signed [LANE_W-1:0] hit_c;
        logic signed [LANE_W-1:0] hit_d;
        logic signed [LANE_W-1:0] miss_a;
        logic signed [LANE_W-1:0] miss_b;
        logic signed [LANE_W-1:0] miss_c;
        logic signed [LANE_W-1:0] miss_d;
        logic last_chunk;
    } out_item_t;

    typedef struct packed {
        chunk_t cur;
        chunk_t nxt;
        logic is_hit;
        logic do_update;
        logic end_of_set;
        row_t row;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_SETTLE,
        BK_BURST
    } back_state_t;

    function automatic chunk_tab_t build_cur_tab();
        chunk_tab_t tab;
        for (int i = 0; i < IDX_COUNT; i++)
        begin
            tab[i] = CHUNK_W'(i % CHUNKS);
        end
        return tab;
    endfunction

    function automatic chunk_tab_t build_nxt_tab();
        chunk_tab_t tab;
        for (int i = 0; i < IDX_COUNT; i++)
        begin
            tab[i] = CHUNK_W'(((i % CHUNKS) + 1) % CHUNKS);
        end
        return tab;
    endfunction

    localparam chunk_tab_t CUR_TAB = build_cur_tab();
    localparam chunk_tab_t NXT_TAB = build_nxt_tab();
    localparam chunk_t LAST_CHUNK = CHUNK_W'(CHUNKS - 1);

endpackage

[sv/delayed_hit_miss_vector_store_core.sv]
// Top level of the delayed hit/miss vector store.
// Throughput: one item per cycle while the command queue has room and no readout runs.
// An item with end_of_set, once the back end pops it, starts a readout burst through the settle
// state: CHUNKS results in all, at one per cycle from the store read ports, slower under stall.
// During a readout the back end takes no commands; the two-entry queue then fills.
// Reset: a clearing pass zeroes every row of all three stores; in_ready stays low during it.
module delayed_hit_miss_vector_store_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dhmvs_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dhmvs_pkg::out_item_t out_data
);

    dhmvs_pkg::back_status_t status;
    dhmvs_pkg::cmd_t push_cmd;
    dhmvs_pkg::cmd_t pop_cmd;
    logic push;
    logic push_ready;
    logic pop;
    logic pop_valid;

    dhmvs_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .status     (status),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    dhmvs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    dhmvs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

[sv/dhmvs_front.sv]
// Front end: accepts input items and turns them into slot commands for the queue.
module dhmvs_front (
    input  logic                    in_valid,
    output logic                    in_ready,
    input  dhmvs_pkg::in_item_t     in_data,
    input  dhmvs_pkg::back_status_t status,
    output logic                    push,
    input  logic                    push_ready,
    output dhmvs_pkg::cmd_t         push_cmd
);

    logic [dhmvs_pkg::PORT_LANES-1:0][dhmvs_pkg::LANE_W-1:0] lanes_all;

    assign lanes_all[0] = in_data.lane_a;
    assign lanes_all[1] = in_data.lane_b;
    assign lanes_all[2] = in_data.lane_c;
    assign lanes_all[3] = in_data.lane_d;

    for (genvar i = 0; i < dhmvs_pkg::LANES; i++)
    begin : g_row
        assign push_cmd.row[i] = lanes_all[i];
    end

    assign push_cmd.cur = dhmvs_pkg::CUR_TAB[in_data.chunk_index];
    assign push_cmd.nxt = dhmvs_pkg::NXT_TAB[in_data.chunk_index];
    assign push_cmd.is_hit = in_data.is_hit;
    assign push_cmd.do_update = in_data.do_update;
    assign push_cmd.end_of_set = in_data.end_of_set;

    assign in_ready = push_ready && !status.clearing;
    assign push = in_valid && in_ready;

endmodule

[sv/dhmvs_queue.sv]
// Short command queue between the front end and the back end.
module dhmvs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            push_ready,
    input  dhmvs_pkg::cmd_t push_cmd,
    output logic            pop_valid,
    input  logic            pop,
    output dhmvs_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = (dhmvs_pkg::QUEUE_DEPTH > 1) ? $clog2(dhmvs_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(dhmvs_pkg::QUEUE_DEPTH + 1);

    dhmvs_pkg::cmd_t entry_reg [dhmvs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != CNT_W'(dhmvs_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];
    assign do_push = push && push_ready;
    assign do_pop = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(dhmvs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(dhmvs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/dhmvs_back.sv]
// Back end: delay line, hit and miss stores, clearing pass and readout bursts.
module dhmvs_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop,
    input  dhmvs_pkg::cmd_t         pop_cmd,
    output dhmvs_pkg::back_status_t status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output dhmvs_pkg::out_item_t    out_data
);

    dhmvs_pkg::row_t delay_mem [dhmvs_pkg::CHUNKS];
    dhmvs_pkg::row_t hit_mem [dhmvs_pkg::CHUNKS];
    dhmvs_pkg::row_t miss_mem [dhmvs_pkg::CHUNKS];

    dhmvs_pkg::back_state_t state_reg;
    dhmvs_pkg::back_state_t state_next;
    dhmvs_pkg::chunk_t clr_idx_reg;
    dhmvs_pkg::chunk_t clr_idx_next;
    dhmvs_pkg::chunk_t burst_idx_reg;
    dhmvs_pkg::chunk_t burst_idx_next;
    logic s2_valid_reg;
    logic s2_hit_reg;
    dhmvs_pkg::chunk_t s2_addr_reg;
    dhmvs_pkg::row_t delay_rd_reg;
    logic out_valid_reg;
    logic out_valid_next;
    dhmvs_pkg::row_t hit_rd_reg;
    dhmvs_pkg::row_t miss_rd_reg;
    dhmvs_pkg::chunk_t out_idx_reg;
    logic out_last_reg;
    logic clearing;
    logic issue;
    logic hit_we;
    logic miss_we;
    dhmvs_pkg::chunk_t store_addr;
    dhmvs_pkg::row_t store_data;
    logic [dhmvs_pkg::PORT_LANES-1:0][dhmvs_pkg::LANE_W-1:0] hit_lane;
    logic [dhmvs_pkg::PORT_LANES-1:0][dhmvs_pkg::LANE_W-1:0] miss_lane;

    always_comb
    begin
        state_next = state_reg;
        clr_idx_next = clr_idx_reg;
        burst_idx_next = burst_idx_reg;
        clearing = 1'b0;
        pop = 1'b0;
        issue = 1'b0;
        case (state_reg)
            dhmvs_pkg::BK_CLEAR:
            begin
                clearing = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == dhmvs_pkg::LAST_CHUNK)
                begin
                    state_next = dhmvs_pkg::BK_RUN;
                end
            end
            dhmvs_pkg::BK_RUN:
            begin
                pop = pop_valid;
                if (pop_valid && pop_cmd.end_of_set)
                begin
                    state_next = dhmvs_pkg::BK_SETTLE;
                end
            end
            dhmvs_pkg::BK_SETTLE:
            begin
                burst_idx_next = '0;
                state_next = dhmvs_pkg::BK_BURST;
            end
            dhmvs_pkg::BK_BURST:
            begin
                issue = !out_valid_reg || out_ready;
                if (issue)
                begin
                    burst_idx_next = burst_idx_reg + 1'b1;
                    if (burst_idx_reg == dhmvs_pkg::LAST_CHUNK)
                    begin
                        state_next = dhmvs_pkg::BK_RUN;
                    end
                end
            end
            default:
            begin
                state_next = dhmvs_pkg::BK_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (clearing)
        begin
            hit_we = 1'b1;
            miss_we = 1'b1;
            store_addr = clr_idx_reg;
            store_data = '0;
        end
        else
        begin
            hit_we = s2_valid_reg && s2_hit_reg;
            miss_we = s2_valid_reg && !s2_hit_reg;
            store_addr = s2_addr_reg;
            store_data = delay_rd_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dhmvs_pkg::BK_CLEAR;
            clr_idx_reg <= '0;
            burst_idx_reg <= '0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_idx_reg <= clr_idx_next;
            burst_idx_reg <= burst_idx_next;
            s2_valid_reg <= pop && pop_cmd.do_update;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            delay_mem[clr_idx_reg] <= '0;
        end
        else if (pop)
        begin
            delay_mem[pop_cmd.cur] <= pop_cmd.row;
        end
        if (pop)
        begin
            delay_rd_reg <= delay_mem[pop_cmd.nxt];
            s2_hit_reg <= pop_cmd.is_hit;
            s2_addr_reg <= pop_cmd.nxt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_we)
        begin
            hit_mem[store_addr] <= store_data;
        end
        if (issue)
        begin
            hit_rd_reg <= hit_mem[burst_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (miss_we)
        begin
            miss_mem[store_addr] <= store_data;
        end
        if (issue)
        begin
            miss_rd_reg <= miss_mem[burst_idx_reg];
            out_idx_reg <= burst_idx_reg;
            out_last_reg <= (burst_idx_reg == dhmvs_pkg::LAST_CHUNK);
        end
    end

    for (genvar i = 0; i < dhmvs_pkg::PORT_LANES; i++)
    begin : g_lane
        if (i < dhmvs_pkg::LANES)
        begin : g_used
            assign hit_lane[i] = hit_rd_reg[i];
            assign miss_lane[i] = miss_rd_reg[i];
        end
        else
        begin : g_unused
            assign hit_lane[i] = '0;
            assign miss_lane[i] = '0;
        end
    end

    assign status.clearing = clearing;
    assign out_valid = out_valid_reg;
    assign out_data.out_chunk_index = dhmvs_pkg::IDX_W'(out_idx_reg);
    assign out_data.hit_a = hit_lane[0];
    assign out_data.hit_b = hit_lane[1];
    assign out_data.hit_c = hit_lane[2];
    assign out_data.hit_d = hit_lane[3];
    assign out_data.miss_a = miss_lane[0];
    assign out_data.miss_b = miss_lane[1];
    assign out_data.miss_c = miss_lane[2];
    assign out_data.miss_d = miss_lane[3];
    assign out_data.last_chunk = out_last_reg;

endmodule

[sv/dhmvs_checker.sv]
// Port-level checker for the delayed hit/miss vector store, bound to the top level.
module dhmvs_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input dhmvs_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Stalled result item changed or dropped.");

    a_burst_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_chunk |=>
            out_valid && (out_data.out_chunk_index == $past(out_data.out_chunk_index) + 1'b1))
        else $error("Readout burst skipped or repeated a chunk.");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_chunk |->
            out_data.out_chunk_index == dhmvs_pkg::IDX_W'(dhmvs_pkg::CHUNKS - 1))
        else $error("Last mark on a chunk other than the final one.");

    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> out_data.out_chunk_index == '0)
        else $error("Readout burst did not start at chunk zero.");

endmodule

bind delayed_hit_miss_vector_store_core dhmvs_checker u_dhmvs_checker (.*);
